/* sv/binary_to_decimal_ascii_macros.svh */
// Assertion macros shared by the binary-to-decimal ASCII RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset
`define BDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true out of reset
`define BDA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* sv/bda_pkg.sv */
// Shared types and constants for the binary-to-decimal ASCII block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

    // Width of one packed decimal digit
    localparam int DIGIT_W = 4;

    // ASCII code of '0', as carried on the 6-bit character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Double-dabble correction: digits at or above this get ADD3_VAL added
    localparam logic [DIGIT_W-1:0] ADD3_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADD3_VAL   = 4'd3;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } bda_state_t;

endpackage

`default_nettype wire

/* sv/bda_front.sv */
// Front end: accepts items, caps the digit count, drops zero-count items
// and holds jobs in a two-entry queue for the back end. Uses binary_to_decimal_ascii_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module bda_front #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10,
    parameter int CNT_W       = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input item
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] in_number,
    input  wire logic [3:0]             in_count,
    // job to the back end
    output logic                        job_valid,
    input  wire logic                   job_pop,
    output logic [VALUE_WIDTH-1:0]      job_number,
    output logic [CNT_W-1:0]            job_count
);

    logic [VALUE_WIDTH-1:0] num_mem_reg [2];
    logic [CNT_W-1:0]       cnt_mem_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             fill_reg, fill_next;
    logic [CNT_W-1:0]       cnt_capped;
    logic                   accept;
    logic                   push;

    // Cap the count; counts above the digit limit emit MAX_DIGITS characters
    always_comb
    begin
        if (int'(in_count) > MAX_DIGITS)
        begin
            cnt_capped = CNT_W'(MAX_DIGITS);
        end
        else
        begin
            cnt_capped = CNT_W'(in_count);
        end
    end

    assign in_ready = (fill_reg != 2'd2);
    assign accept   = in_valid && in_ready;
    // zero-count items produce nothing and are not queued
    assign push     = accept && (in_count != 4'd0);

    assign job_valid  = (fill_reg != 2'd0);
    assign job_number = num_mem_reg[rd_ptr_reg];
    assign job_count  = cnt_mem_reg[rd_ptr_reg];

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !job_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && job_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            num_mem_reg[wr_ptr_reg] <= in_number;
            cnt_mem_reg[wr_ptr_reg] <= cnt_capped;
        end
    end

`include "binary_to_decimal_ascii_macros.svh"

    `BDA_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= 2'd2, "queue fill out of range")
    `BDA_NEVER(a_pop_empty, clk, rst_n, job_pop && (fill_reg == 2'd0), "pop from empty queue")
    `BDA_ASSERT(a_fill_grow, clk, rst_n, (push && !job_pop) |=> (fill_reg == $past(fill_reg) + 2'd1), "fill did not grow on push")
    `BDA_NEVER(a_zero_job, clk, rst_n, job_valid && (job_count == CNT_W'(0)), "zero-count job queued")

endmodule

`default_nettype wire

/* sv/bda_back.sv */
// Back end: shift-and-add-3 conversion, one binary bit per cycle, then
// streams the digits out as ASCII through an output register. Uses bda_pkg and binary_to_decimal_ascii_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module bda_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // job from the front end
    input  wire logic                   job_valid,
    output logic                        job_pop,
    input  wire logic [VALUE_WIDTH-1:0] job_number,
    input  wire logic [CNT_W-1:0]       job_count,
    // result item
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [5:0]                  out_char,
    output logic                        out_last
);

    // Decimal digits needed for the widest value: floor(W*log10(2)) + 1
    localparam int NUM_BCD = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DW      = bda_pkg::DIGIT_W;

    bda_pkg::bda_state_t    state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DW-1:0]          bcd_reg [NUM_BCD];
    logic [DW-1:0]          bcd_next [NUM_BCD];
    logic [DW-1:0]          bcd_adj [NUM_BCD];
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic [DW-1:0]          sel_digit;
    logic                   conv_done;
    logic                   emit_go;

    assign conv_done = (bit_reg == BIT_W'(VALUE_WIDTH - 1));
    assign emit_go   = (state_reg == bda_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    // Add-3 correction on each digit, then the whole chain shifts left by one
    always_comb
    begin
        for (int i = 0; i < NUM_BCD; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= bda_pkg::ADD3_LIMIT) ?
                         bcd_reg[i] + bda_pkg::ADD3_VAL : bcd_reg[i];
        end
    end

    // Digit at the emit position; positions past the converted width read zero
    always_comb
    begin
        sel_digit = '0;
        for (int i = 0; i < NUM_BCD; i++)
        begin
            if (int'(idx_reg) == i)
            begin
                sel_digit = bcd_reg[i];
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bda_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = bda_pkg::ST_CONV;
                end
            end
            bda_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = bda_pkg::ST_EMIT;
                end
            end
            bda_pkg::ST_EMIT:
            begin
                if (emit_go && (idx_reg == CNT_W'(0)))
                begin
                    state_next = bda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bda_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        job_pop        = 1'b0;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            bda_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop  = 1'b1;
                    bin_next = job_number;
                    cnt_next = job_count;
                    bit_next = '0;
                    for (int i = 0; i < NUM_BCD; i++)
                    begin
                        bcd_next[i] = '0;
                    end
                end
            end
            bda_pkg::ST_CONV:
            begin
                bcd_next[0] = {bcd_adj[0][DW-2:0], bin_reg[VALUE_WIDTH-1]};
                for (int i = 1; i < NUM_BCD; i++)
                begin
                    bcd_next[i] = {bcd_adj[i][DW-2:0], bcd_adj[i-1][DW-1]};
                end
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_next = bit_reg + BIT_W'(1);
                if (conv_done)
                begin
                    idx_next = cnt_reg - CNT_W'(1);
                end
            end
            bda_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = bda_pkg::ASCII_ZERO + 6'(sel_digit);
                    out_last_next  = (idx_reg == CNT_W'(0));
                    idx_next       = idx_reg - CNT_W'(1);
                end
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        bit_reg      <= bit_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

`include "binary_to_decimal_ascii_macros.svh"

    `BDA_ASSERT(a_pop_idle, clk, rst_n, job_pop |-> (state_reg == bda_pkg::ST_IDLE), "job taken while busy")
    `BDA_ASSERT(a_idx_range, clk, rst_n, (state_reg == bda_pkg::ST_EMIT) |-> (idx_reg < cnt_reg), "emit index past count")
    `BDA_ASSERT(a_digit_ok, clk, rst_n, (state_reg == bda_pkg::ST_EMIT) |-> (sel_digit <= 4'd9), "non-decimal digit")
    `BDA_ASSERT(a_last_idle, clk, rst_n, (emit_go && (idx_reg == CNT_W'(0))) |=> (state_reg == bda_pkg::ST_IDLE), "no return to idle after last")

endmodule

`default_nettype wire

/* sv/binary_to_decimal_ascii.sv */
// An accepted item is written into a two-entry queue, which absorbs bursts; the
// bit-serial converter takes it when idle and runs it through shift-and-add-3 one
// bit at a time, then the characters leave through the output register, one
// character per cycle while the receiver is ready. A new item enters the converter
// only after the last character of the previous one has been issued.
// Reset (rst_n, async, active low) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: number [VALUE_WIDTH-1:0], digit_count [VALUE_WIDTH+3:VALUE_WIDTH], zero pad
    input  wire logic [((VALUE_WIDTH+4+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: ascii_char [5:0], zero pad [7:6]
    output logic [7:0]                  m_axis_tdata,
    // tlast: last_digit
    output logic                        m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic                   job_valid;
    logic                   job_pop;
    logic [VALUE_WIDTH-1:0] job_number;
    logic [CNT_W-1:0]       job_count;
    logic [5:0]             out_char;

    bda_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_number  (s_axis_tdata[VALUE_WIDTH-1:0]),
        .in_count   (s_axis_tdata[VALUE_WIDTH+3:VALUE_WIDTH]),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job_number (job_number),
        .job_count  (job_count)
    );

    bda_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job_number (job_number),
        .job_count  (job_count),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (out_char),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_char};

endmodule

`default_nettype wire

/* dv/binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_decimal_ascii: number/count items in, ASCII digits out.
// Predicts the characters of every accepted item and checks them in order; uses bda_pkg.

module binary_to_decimal_ascii_tb;

    localparam int NUM_W     = 32;
    localparam int MAX_DIG   = 10;
    localparam int IN_W      = ((NUM_W + 4 + 7) / 8) * 8;
    localparam int TAIL_LEN  = 40;   // last items run with no idling
    localparam int HOLD_LEN  = 300;  // long receiver hold-off, in cycles
    localparam int HOLD_AT   = 40;   // characters seen before the hold-off starts
    localparam int SETTLE    = 60;   // cycles after the last character

    // one request to render a number
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [3:0]       count;
        logic             drain_first;  // wait until all characters are out
    } render_req_t;

    // one expected character
    typedef struct packed {
        logic [5:0] ascii;
        logic       last;
    } digit_char_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [7:0]      m_axis_tdata;
    logic            m_axis_tlast;

    render_req_t number_q[$];
    digit_char_t char_q[$];
    int          fail_cnt = 0;
    int          chars_seen = 0;
    bit          in_fire = 1'b0;
    bit          tail_phase = 1'b0;
    int          src_gap = 0;
    int          sink_stall = 0;
    int          sink_hold = 0;
    bit          hold_done = 1'b0;

    binary_to_decimal_ascii i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected characters of one number: low-order digits, most significant first
    task automatic render_digits(input logic [NUM_W-1:0] number, input logic [3:0] count);
        logic [3:0]       digits[MAX_DIG];
        logic [NUM_W-1:0] rest;
        int               n;
        digit_char_t      c;
        rest = number;
        n = (count > MAX_DIG) ? MAX_DIG : int'(count);
        for (int k = 0; k < MAX_DIG; k++)
        begin
            digits[k] = 4'(rest % 10);
            rest = rest / 10;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            c.ascii = bda_pkg::ASCII_ZERO + 6'(digits[k]);
            c.last  = (k == 0);
            char_q.push_back(c);
        end
    endtask

    task automatic queue_req(input logic [NUM_W-1:0] number, input logic [3:0] count,
                             input logic drain_first);
        render_req_t r;
        r.number = number;
        r.count = count;
        r.drain_first = drain_first;
        number_q.push_back(r);
    endtask

    // Random number biased toward decimal edge values
    function automatic logic [NUM_W-1:0] rand_number();
        logic [63:0] p;
        int          k;
        p = 64'd1;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 9);
            2: return $urandom_range(0, 99999);
            3:
            begin
                repeat (k) p = p * 10;
                return NUM_W'(p) - NUM_W'($urandom_range(0, 1));
            end
            4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default:
            begin
                repeat (k + 1) p = p * 10;
                return NUM_W'(p - 1);
            end
        endcase
    endfunction

    // Random count: mostly 1..10, some zero and some above the cap
    function automatic logic [3:0] rand_count();
        int v;
        v = $urandom_range(0, 19);
        return (v > 15) ? 4'd10 : 4'(v);
    endfunction

    // Sender: holds an item until accepted, then idles or moves on
    always @(negedge clk)
    begin
        render_req_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_fire)
            begin
                // keep offering the same item
            end
            else if (src_gap != 0)
            begin
                src_gap = src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (number_q.size() == 0
                     || (number_q[0].drain_first && char_q.size() != 0))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                nxt = number_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0000, nxt.count, nxt.number};
                if (!tail_phase && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 13);
            end
        end
    end

    // Receiver: random stall bursts until the tail, and one long hold-off after HOLD_AT characters
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && chars_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                sink_hold = HOLD_LEN;
            end
            if (sink_hold != 0)
            begin
                sink_hold = sink_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stall != 0)
            begin
                sink_stall = sink_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!tail_phase && $urandom_range(0, 7) == 0)
            begin
                sink_stall = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        digit_char_t want;
        in_fire = s_axis_tvalid && s_axis_tready;
        tail_phase = (number_q.size() < TAIL_LEN);
        if (in_fire)
            render_digits(s_axis_tdata[NUM_W-1:0], s_axis_tdata[NUM_W+3:NUM_W]);
        if (m_axis_tvalid && m_axis_tready)
        begin
            chars_seen = chars_seen + 1;
            if (char_q.size() == 0)
            begin
                $display("%0t: unexpected character: expected none actual 0x%02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                fail_cnt = fail_cnt + 1;
            end
            else
            begin
                want = char_q.pop_front();
                if (m_axis_tdata[5:0] !== want.ascii)
                begin
                    $display("%0t: ascii_char mismatch: expected %0d actual %0d",
                             $time, want.ascii, m_axis_tdata[5:0]);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_axis_tdata[7:6] !== 2'b00)
                begin
                    $display("%0t: tdata pad mismatch: expected 0 actual %0d",
                             $time, m_axis_tdata[7:6]);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last_digit mismatch: expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        // directed: every count, cap, extremes, leading zeros, dropped digits
        queue_req(32'd12345, 4'd0, 1'b0);
        for (int c = 1; c <= MAX_DIG; c++)
            queue_req(32'd1234567890, 4'(c), 1'b0);
        for (int c = 11; c <= 15; c++)
            queue_req(32'd4294967295 - 32'(c), 4'(c), 1'b0);
        queue_req(32'd0, 4'd10, 1'b0);
        queue_req(32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_req(32'hFFFF_FFFF, 4'd3, 1'b0);
        queue_req(32'd7, 4'd10, 1'b0);
        queue_req(32'd1000000000, 4'd10, 1'b0);
        queue_req(32'd999999999, 4'd9, 1'b0);
        queue_req(32'hFFFF_FFFF, 4'd0, 1'b0);

        // random: two items wait for the output to drain first
        for (int i = 0; i < 410; i++)
            queue_req(rand_number(), rand_count(), (i == 5) || (i == 200));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (number_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        @(negedge clk);
        while (char_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_cnt == 0)
            $display("[binary_to_decimal_ascii] OK");
        else
            $display("[binary_to_decimal_ascii] ERROR");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("[binary_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule
